>>> hw/rtl/frt_pkg.sv
// Shared types, widths and codes for the fragment reassembly tracker.
`timescale 1ns / 1ps

package frt_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int ID_W     = 32;
    localparam int FRAG_W   = 16;
    localparam int BYTES_W  = 24;
    localparam int SUM_W    = BYTES_W + 1;
    localparam int STATUS_W = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int PEND_W   = 5;

    // Queue between the front and the back engine.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_MAX_PACKET_BYTES = 1'b0;
    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 24'd65536;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_ORDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DISCARDED    = 3'd6;

    localparam logic ACT_FRAGMENT = 1'b0;
    localparam logic ACT_DISCARD  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   pkt_id;
        logic [FRAG_W-1:0] frag_index;
        logic [FRAG_W-1:0] frag_count;
        logic [FRAG_W-1:0] frag_length;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [BYTES_W-1:0]    write_offset;
        logic [BYTES_W-1:0]    total_length;
        logic [PEND_W-1:0]     pending_count;
    } out_item_t;

    // A classified transaction as it waits for the back engine.
    typedef struct packed {
        in_item_t item;
        logic     bad_header;
    } q_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_EXEC
    } back_state_t;

endpackage

>>> hw/rtl/frt_front.sv
// Front end: accepts transactions, flags malformed headers and queues them.
`timescale 1ns / 1ps

module frt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  frt_pkg::in_item_t item,
    output logic             q_valid,
    input  logic             q_pop,
    output frt_pkg::q_item_t q_entry
);
    import frt_pkg::*;

    q_item_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;
    q_item_t               new_entry;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;
    assign q_entry = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.item       = item;
        new_entry.bad_header = (item.frag_count == '0) || (item.frag_index >= item.frag_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

>>> hw/rtl/frt_back.sv
// Back engine: slot table, id match, per-fragment update and the result register.
`timescale 1ns / 1ps

module frt_back #(
    parameter int SLOTS = frt_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  frt_pkg::q_item_t             q_entry,
    input  logic [frt_pkg::BYTES_W-1:0]  max_bytes,
    output logic                         empty,
    input  logic                         pop,
    output frt_pkg::out_item_t           result
);
    import frt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    back_state_t state_reg;
    back_state_t state_next;
    logic        exec_fire;

    q_item_t     work_reg;
    logic        hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic        free_reg;
    logic [SLOT_W-1:0] free_idx_reg;

    logic              valid_reg     [SLOTS];
    logic [ID_W-1:0]   packet_reg    [SLOTS];
    logic [FRAG_W-1:0] expected_reg  [SLOTS];
    logic [FRAG_W-1:0] next_frag_reg [SLOTS];
    logic [BYTES_W-1:0] bytes_reg    [SLOTS];
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  live_next;

    out_item_t   result_reg;
    logic        result_valid_reg;

    logic              match_hit;
    logic [SLOT_W-1:0] match_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;

    in_item_t          it;
    logic [FRAG_W-1:0] cur_expected;
    logic [FRAG_W-1:0] cur_next;
    logic [BYTES_W-1:0] cur_bytes;
    logic [SUM_W-1:0]  sum;
    logic [FRAG_W-1:0] next_idx;
    logic              last_frag;
    logic              do_free;
    logic              do_open;
    logic              do_advance;
    out_item_t         res;

    assign empty  = !result_valid_reg;
    assign result = result_reg;

    // Control sequencer: take one transaction, match it, then execute it.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_MATCH;
                end
            end
            BK_MATCH:
            begin
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (!result_valid_reg || pop)
                begin
                    exec_fire  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Associative id match and lowest free slot; the lowest index wins.
    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (packet_reg[i] == work_reg.item.pkt_id))
            begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_entry;
        end
        if (state_reg == BK_MATCH)
        begin
            hit_reg      <= match_hit;
            hit_idx_reg  <= match_idx;
            free_reg     <= free_any;
            free_idx_reg <= free_idx;
        end
    end

    // Decision for one transaction against the matched slot.
    always_comb
    begin
        it           = work_reg.item;
        cur_expected = expected_reg[hit_idx_reg];
        cur_next     = next_frag_reg[hit_idx_reg];
        cur_bytes    = bytes_reg[hit_idx_reg];
        sum          = {1'b0, cur_bytes} + SUM_W'(it.frag_length);
        next_idx     = it.frag_index + 1'b1;
        last_frag    = (next_idx == it.frag_count);
        do_free      = 1'b0;
        do_open      = 1'b0;
        do_advance   = 1'b0;
        res          = '0;
        res.status   = ST_ACCEPTED;

        if (it.action == ACT_DISCARD)
        begin
            res.status = ST_DISCARDED;
            do_free    = hit_reg;
        end
        else if (work_reg.bad_header)
        begin
            res.status = ST_INVALID;
        end
        else if (!hit_reg)
        begin
            if (it.frag_index != '0)
            begin
                res.status = ST_OUT_OF_ORDER;
            end
            else if (BYTES_W'(it.frag_length) > max_bytes)
            begin
                res.status = ST_TOO_LARGE;
            end
            else if (!free_reg)
            begin
                res.status = ST_TABLE_FULL;
            end
            else
            begin
                res.slot = SLOT_OUT_W'(free_idx_reg);
                if (last_frag)
                begin
                    // A single-fragment packet opens and closes in the same step.
                    res.status       = ST_COMPLETED;
                    res.total_length = BYTES_W'(it.frag_length);
                end
                else
                begin
                    do_open = 1'b1;
                end
            end
        end
        else if ((cur_expected != it.frag_count) || (cur_next != it.frag_index))
        begin
            res.status = ST_OUT_OF_ORDER;
            do_free    = 1'b1;
        end
        else if (sum > {1'b0, max_bytes})
        begin
            res.status = ST_TOO_LARGE;
            do_free    = 1'b1;
        end
        else
        begin
            res.slot         = SLOT_OUT_W'(hit_idx_reg);
            res.write_offset = cur_bytes;
            if (last_frag)
            begin
                res.status       = ST_COMPLETED;
                res.total_length = sum[BYTES_W-1:0];
                do_free          = 1'b1;
            end
            else
            begin
                do_advance = 1'b1;
            end
        end

        if (do_open)
        begin
            live_next = live_reg + 1'b1;
        end
        else if (do_free)
        begin
            live_next = live_reg - 1'b1;
        end
        else
        begin
            live_next = live_reg;
        end
        res.pending_count = PEND_W'(live_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            live_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                if (do_open)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (do_free)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
                live_reg         <= live_next;
                result_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            result_reg <= res;
            if (do_open)
            begin
                packet_reg[free_idx_reg]    <= it.pkt_id;
                expected_reg[free_idx_reg]  <= it.frag_count;
                next_frag_reg[free_idx_reg] <= next_idx;
                bytes_reg[free_idx_reg]     <= BYTES_W'(it.frag_length);
            end
            if (do_advance)
            begin
                next_frag_reg[hit_idx_reg] <= next_idx;
                bytes_reg[hit_idx_reg]     <= sum[BYTES_W-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/fragment_reassembly_tracker_unit.sv
// Top level of the fragment reassembly tracker: configuration register and the two engines.
//
//   Channel   Handshake            Payload
//   input     push / full          item   (in_item_t)
//   result    empty / pop          result (out_item_t)
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// Each transaction passes through the back engine in order: queue pop, id match across
// the slot table, then the slot update that also loads the result register.
// The front takes a new transaction every cycle while its two-entry queue has room.
// A waiting result stalls only the update cycle; the queue keeps filling meanwhile.
// Reset empties the slot table at once through per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps

module fragment_reassembly_tracker_unit #(
    parameter int SLOTS = frt_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  frt_pkg::in_item_t           item,
    output logic                        empty,
    input  logic                        pop,
    output frt_pkg::out_item_t          result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frt_pkg::ADDR_W-1:0]  paddr,
    input  logic [frt_pkg::DATA_W-1:0]  pwdata,
    output logic [frt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import frt_pkg::*;

    logic [BYTES_W-1:0] max_packet_bytes_reg;
    logic               cfg_write;
    logic               q_valid;
    logic               q_pop;
    q_item_t            q_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_MAX_PACKET_BYTES))
        begin
            max_packet_bytes_reg <= pwdata[BYTES_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_PACKET_BYTES)
        begin
            prdata = DATA_W'(max_packet_bytes_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    frt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_entry (q_entry)
    );

    frt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .max_bytes (max_packet_bytes_reg),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Only a completed packet reports a total length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status != ST_COMPLETED)) |-> (result.total_length == '0))
        else $error("total length reported without completion");

    // Rejected and discarded transactions carry no slot and no offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status != ST_COMPLETED) && (result.status != ST_ACCEPTED))
        |-> ((result.slot == '0) && (result.write_offset == '0)))
        else $error("slot or offset reported for a rejected transaction");

    // A completed packet never reports more bytes than the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status == ST_COMPLETED))
        |-> (result.total_length <= max_packet_bytes_reg))
        else $error("completed packet exceeds the size limit");

    // The queue is never popped while it holds nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
